// ===== src/cas_pkg.sv =====
// shared types and constants for contrast_adaptive_sharpen
// no dependencies
`default_nettype none
package cas_pkg;

	localparam int unsigned ChW    = 8;
	localparam int unsigned NumCh  = 3;
	localparam int unsigned SharpW = 9;
	localparam logic [SharpW-1:0] SharpOne = 9'd256;

	// stage map of one lane: stage 0 takes the taps, then the amp division,
	// square root, weight, numerator, output division and the final select
	localparam int unsigned AmpSteps  = 17;
	localparam int unsigned SqrtSteps = 16;
	localparam int unsigned DivSteps  = 9;
	localparam int unsigned AmpLast   = AmpSteps;
	localparam int unsigned SqrtLast  = AmpLast + SqrtSteps;
	localparam int unsigned MagStage  = SqrtLast + 1;
	localparam int unsigned NumStage  = MagStage + 1;
	localparam int unsigned DivLast   = NumStage + DivSteps;
	localparam int unsigned LastStage = DivLast + 1;
	localparam int unsigned Latency   = LastStage + 1;

	// five taps of one colour channel
	typedef struct packed {
		logic [ChW-1:0] c;
		logic [ChW-1:0] u;
		logic [ChW-1:0] l;
		logic [ChW-1:0] r;
		logic [ChW-1:0] d;
	} tap_t;

endpackage
`default_nettype wire

// ===== src/cas_lane.sv =====
// one colour channel of the sharpener, fully pipelined (one item per cycle while en is high)
// depends on cas_pkg
`default_nettype none
module cas_lane (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire cas_pkg::tap_t                tap,
	input  wire logic                         bypass,
	input  wire logic [cas_pkg::SharpW-1:0]   sharp,
	output logic      [cas_pkg::ChW-1:0]      result
);
	// per-stage carried state
	typedef struct packed {
		logic [7:0]  c;
		logic [9:0]  sum;
		logic        byp;
		logic [8:0]  s;
		logic [7:0]  mx;
		logic [7:0]  arem;   // amp division remainder
		logic [16:0] amp;    // amp quotient bits
		logic [31:0] sv;     // sqrt radicand, consumed from the top
		logic [17:0] sr;     // sqrt remainder
		logic [15:0] root;
		logic [12:0] mag;
		logic        neg;
		logic [23:0] num;
		logic [16:0] den;
		logic [16:0] drem;   // output division remainder
		logic [8:0]  q;
		logic [7:0]  res;
	} stage_t;

	stage_t pipe_q [cas_pkg::Latency];
	stage_t nx [cas_pkg::Latency];

	always_comb begin
		logic [7:0]  mn, mx, lim;
		logic [8:0]  ar;
		logic        abit;
		logic [15:0] amp_sat;
		logic [19:0] tsr, trial;
		logic [24:0] prod;
		logic [22:0] lobe;
		logic signed [25:0] sn;
		logic [17:0] dr;
		mn = tap.c; mx = tap.c;
		if (tap.u < mn) mn = tap.u;
		if (tap.l < mn) mn = tap.l;
		if (tap.r < mn) mn = tap.r;
		if (tap.d < mn) mn = tap.d;
		if (tap.u > mx) mx = tap.u;
		if (tap.l > mx) mx = tap.l;
		if (tap.r > mx) mx = tap.r;
		if (tap.d > mx) mx = tap.d;
		lim = 8'd255 - mx;
		ar = '0;
		abit = 1'b0;
		amp_sat = '0;
		tsr = '0;
		trial = '0;
		prod = '0;
		lobe = '0;
		sn = '0;
		dr = '0;
		nx[0] = '0;
		nx[0].c = tap.c;
		nx[0].sum = {2'b0, tap.u} + {2'b0, tap.l} + {2'b0, tap.r} + {2'b0, tap.d};
		nx[0].byp = bypass || (sharp == '0);
		nx[0].s = (sharp > cas_pkg::SharpOne) ? cas_pkg::SharpOne : sharp;
		nx[0].mx = mx;
		nx[0].arem = (mn < lim) ? mn : lim;
		for (int unsigned i = 1; i < cas_pkg::Latency; i++) begin
			nx[i] = pipe_q[i-1];
			if (i <= cas_pkg::AmpLast) begin
				// restoring division of numa * 2^16 by mx, integer bit first
				ar = (i == 1) ? {1'b0, pipe_q[i-1].arem} : {pipe_q[i-1].arem, 1'b0};
				abit = (ar >= {1'b0, pipe_q[i-1].mx});
				nx[i].arem = abit ? 8'(ar - {1'b0, pipe_q[i-1].mx}) : ar[7:0];
				nx[i].amp = {pipe_q[i-1].amp[15:0], abit};
				if (i == cas_pkg::AmpLast) begin
					// zero max gives zero, a quotient of exactly one saturates
					amp_sat = (pipe_q[i-1].mx == '0) ? 16'h0 :
						nx[i].amp[16] ? 16'hFFFF : nx[i].amp[15:0];
					nx[i].sv = {amp_sat, 16'h0};
				end
			end else if (i <= cas_pkg::SqrtLast) begin
				// digit-by-digit square root, two radicand bits a stage
				tsr = {pipe_q[i-1].sr, pipe_q[i-1].sv[31:30]};
				trial = {2'b0, pipe_q[i-1].root, 2'b01};
				nx[i].sv = {pipe_q[i-1].sv[29:0], 2'b00};
				if (tsr >= trial) begin
					nx[i].sr = 18'(tsr - trial);
					nx[i].root = {pipe_q[i-1].root[14:0], 1'b1};
				end else begin
					nx[i].sr = tsr[17:0];
					nx[i].root = {pipe_q[i-1].root[14:0], 1'b0};
				end
			end else if (i == cas_pkg::MagStage) begin
				prod = {9'd0, pipe_q[i-1].root} * {16'd0, pipe_q[i-1].s};
				nx[i].mag = prod[23:11];
			end else if (i == cas_pkg::NumStage) begin
				lobe = {13'd0, pipe_q[i-1].sum} * {10'd0, pipe_q[i-1].mag};
				sn = $signed({2'b0, pipe_q[i-1].c, 16'h0}) - $signed({3'b0, lobe});
				nx[i].neg = (sn <= 26'sd0);
				nx[i].num = sn[23:0];
				nx[i].den = 17'h10000 - {2'b0, pipe_q[i-1].mag, 2'b0};
				// quotient stays below 512, so the top bits start below den
				nx[i].drem = {2'b0, sn[23:9]};
				nx[i].q = '0;
			end else if (i <= cas_pkg::DivLast) begin
				// restoring division num/den, one quotient bit a stage
				dr = {pipe_q[i-1].drem, pipe_q[i-1].num[8]};
				nx[i].num = {pipe_q[i-1].num[22:0], 1'b0};
				if (dr >= {1'b0, pipe_q[i-1].den}) begin
					nx[i].drem = 17'(dr - {1'b0, pipe_q[i-1].den});
					nx[i].q = {pipe_q[i-1].q[7:0], 1'b1};
				end else begin
					nx[i].drem = dr[16:0];
					nx[i].q = {pipe_q[i-1].q[7:0], 1'b0};
				end
			end else begin
				nx[i].res = pipe_q[i-1].byp ? pipe_q[i-1].c :
					pipe_q[i-1].neg ? 8'd0 :
					pipe_q[i-1].q[8] ? 8'd255 : pipe_q[i-1].q[7:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < cas_pkg::Latency; i++) pipe_q[i] <= nx[i];
		end
	end

	assign result = pipe_q[cas_pkg::LastStage].res;
endmodule
`default_nettype wire

// ===== src/contrast_adaptive_sharpen.sv =====
// top level of contrast_adaptive_sharpen: three channel lanes and the rgba merge
// depends on cas_pkg and cas_lane
//
// usage: pixels arrive on s_axis (five cross taps, alpha, border flag), one per clock;
// sharpened rgba leaves on m_axis. the sharpness register must be written through
// cfg_valid/cfg_ready/cfg_data only while no item is in flight; the block does not enforce this.
// pipeline: 46 stages (tap min/max, 17 amp division steps, 16 square root
// steps, weight, numerator, 9 output division steps, final select).
// throughput: one item per clock while m_axis does not stall; each lane is a pipeline
// with one stage per step, and the three colour lanes run side by side.
// when m_axis stalls with a valid item, the whole pipeline holds and s_axis_tready
// drops in the same cycle, so no item is lost.
// reset clears the valid bits and the sharpness register to 0 (pass-through).
`default_nettype none
module contrast_adaptive_sharpen (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [cas_pkg::SharpW-1:0]   cfg_data,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata: centre_rgb, up_rgb, left_rgb, right_rgb, down_rgb, centre_alpha
	input  wire logic [127:0]                 s_axis_tdata,
	// tuser: on_border
	input  wire logic                         s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// tdata: out_red, out_green, out_blue, out_alpha
	output logic [31:0]                       m_axis_tdata
);
	logic [cas_pkg::SharpW-1:0] sharp_q;
	logic [cas_pkg::Latency-1:0] vld_q;
	logic [7:0] alpha_q [cas_pkg::Latency];
	logic en;
	logic [cas_pkg::ChW-1:0] res [cas_pkg::NumCh];
	cas_pkg::tap_t taps [cas_pkg::NumCh];

	assign cfg_ready = 1'b1;
	assign en = m_axis_tready || !m_axis_tvalid;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[cas_pkg::Latency-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sharp_q <= '0;
			vld_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) sharp_q <= cfg_data;
			if (en) vld_q <= {vld_q[cas_pkg::Latency-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_q[0] <= s_axis_tdata[127:120];
			for (int i = 1; i < cas_pkg::Latency; i++) alpha_q[i] <= alpha_q[i-1];
		end
	end

	for (genvar g = 0; g < cas_pkg::NumCh; g++) begin : g_lane
		assign taps[g] = {s_axis_tdata[8*g +: 8], s_axis_tdata[24 + 8*g +: 8],
			s_axis_tdata[48 + 8*g +: 8], s_axis_tdata[72 + 8*g +: 8],
			s_axis_tdata[96 + 8*g +: 8]};
		cas_lane u_lane (
			.clk(clk), .en(en), .tap(taps[g]), .bypass(s_axis_tuser),
			.sharp(sharp_q), .result(res[g])
		);
	end

	assign m_axis_tdata = {alpha_q[cas_pkg::Latency-1], res[2], res[1], res[0]};
endmodule
`default_nettype wire
